FILE: hdl/bsia_pkg.sv
// ----------------------------------------------------------------------------
// bsia_pkg
// Types and codes shared by the bounded stack with indexed access.
// ----------------------------------------------------------------------------
package bsia_pkg;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CHANGE = 3'd3,
        CMD_DUMP   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_UNDERFLOW = 3'd2,
        STS_INVALID   = 3'd3,
        STS_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]        position;
    } in_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } out_beat_t;

endpackage

FILE: hdl/bsia_ram.sv
// ----------------------------------------------------------------------------
// bsia_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bsia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/bounded_stack_with_indexed_access.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_indexed_access
// LIFO stack of signed words with peek and change at a depth from the top
// and a dump of all entries from top to bottom.
// ----------------------------------------------------------------------------
//  Channel  Ports               Beat        Direction
//  s_       s_valid/s_ready     in_beat_t   command in
//  m_       m_valid/m_ready     out_beat_t  result out
//
//  Push, change and every error status load the result register in the cycle
//  after the command is taken. Pop and peek pass through the registered read
//  of the entry RAM and ST_READ; a dump makes one RAM read per entry.
//  aresetn is synchronous, active low, and empties the stack; the entry RAM
//  is not cleared. A stalled result holds the block; no new command is taken
//  until the result register can be loaded.
// ----------------------------------------------------------------------------
module bounded_stack_with_indexed_access #(
    parameter int DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsia_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bsia_pkg::out_beat_t  m_data
);

    import bsia_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] dump_idx_reg, dump_idx_next;
    logic          out_valid_reg, out_valid_next;
    out_beat_t     out_reg, out_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic            out_free;
    logic            accept;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] diff;

    bsia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign pos_ext  = CMPW'(s_data.position);
    assign cnt_ext  = CMPW'(count_reg);
    assign diff     = cnt_ext - pos_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_idx_reg <= dump_idx_next;
        out_reg      <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        rd_en          = 1'b0;
        rd_addr        = AW'(count_reg - 1'b1);

        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (accept) begin
                    out_next.data   = '0;
                    out_next.status = STS_OK;
                    out_next.last   = 1'b1;
                    case (s_data.command)
                        CMD_PUSH: begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                out_next.status = STS_OVERFLOW;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STS_UNDERFLOW;
                            end else begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        CMD_PEEK, CMD_CHANGE: begin
                            if (s_data.position == '0) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STS_INVALID;
                            end else if (pos_ext > cnt_ext) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STS_UNDERFLOW;
                            end else if (s_data.command == CMD_PEEK) begin
                                rd_en      = 1'b1;
                                rd_addr    = diff[AW-1:0];
                                state_next = ST_READ;
                            end else begin
                                out_valid_next = 1'b1;
                                wr_en          = 1'b1;
                                wr_addr        = diff[AW-1:0];
                            end
                        end
                        CMD_DUMP: begin
                            if (count_reg == '0) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STS_EMPTY;
                            end else begin
                                rd_en         = 1'b1;
                                dump_idx_next = AW'(count_reg - 1'b1);
                                state_next    = ST_DUMP;
                            end
                        end
                        default: begin
                            // Unknown command: taken and dropped without a result.
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next.data   = rd_data;
                    out_next.status = STS_OK;
                    out_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DUMP: begin
                // The RAM output holds the entry at dump_idx_reg until the next read.
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next.data   = rd_data;
                    out_next.status = STS_OK;
                    out_next.last   = (dump_idx_reg == '0);
                    if (dump_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = dump_idx_reg - 1'b1;
                        dump_idx_next = dump_idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("stack count exceeds capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == CMD_PUSH && count_reg != CW'(DEPTH))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not raise the count");

    a_mid_beat_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> state_reg == ST_DUMP)
        else $error("non-final result outside a dump");

    a_dump_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP && out_free && dump_idx_reg == '0)
        |=> (state_reg == ST_IDLE && m_valid && m_data.last))
        else $error("dump did not end with a final beat");
`endif

endmodule

FILE: bench/stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// Watches both channels of the bounded stack, keeps its own copy of the
// stack contents, predicts every result beat and compares it in order.
// ----------------------------------------------------------------------------
module stack_checker #(
    parameter int DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bsia_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bsia_pkg::out_beat_t m_data,
    output int                  fail_count,
    output int                  outstanding
);

    import bsia_pkg::*;

    logic signed [WORD_W-1:0] stack_words [DEPTH];
    int                       stack_count = 0;
    out_beat_t                beats_due [$];
    int                       mismatches  = 0;

    function automatic out_beat_t make_beat(input logic signed [WORD_W-1:0] data,
                                            input status_t status,
                                            input logic last);
        out_beat_t b;
        b.data   = data;
        b.status = status;
        b.last   = last;
        return b;
    endfunction

    // Applies one command to the shadow stack and queues the beats it causes.
    task automatic apply_command(input in_beat_t cmd);
        int idx;
        case (cmd_t'(cmd.command))
            CMD_PUSH: begin
                if (stack_count >= DEPTH) begin
                    beats_due.push_back(make_beat('0, STS_OVERFLOW, 1'b1));
                end else begin
                    stack_words[stack_count] = cmd.value;
                    stack_count++;
                    beats_due.push_back(make_beat('0, STS_OK, 1'b1));
                end
            end
            CMD_POP: begin
                if (stack_count == 0) begin
                    beats_due.push_back(make_beat('0, STS_UNDERFLOW, 1'b1));
                end else begin
                    stack_count--;
                    beats_due.push_back(make_beat(stack_words[stack_count], STS_OK, 1'b1));
                end
            end
            CMD_PEEK, CMD_CHANGE: begin
                // A zero position is rejected before the depth is looked at.
                if (cmd.position == '0) begin
                    beats_due.push_back(make_beat('0, STS_INVALID, 1'b1));
                end else if (int'(cmd.position) > stack_count) begin
                    beats_due.push_back(make_beat('0, STS_UNDERFLOW, 1'b1));
                end else begin
                    idx = stack_count - int'(cmd.position);
                    if (cmd.command == CMD_PEEK) begin
                        beats_due.push_back(make_beat(stack_words[idx], STS_OK, 1'b1));
                    end else begin
                        stack_words[idx] = cmd.value;
                        beats_due.push_back(make_beat('0, STS_OK, 1'b1));
                    end
                end
            end
            CMD_DUMP: begin
                if (stack_count == 0) begin
                    beats_due.push_back(make_beat('0, STS_EMPTY, 1'b1));
                end else begin
                    for (idx = stack_count - 1; idx >= 0; idx--) begin
                        beats_due.push_back(make_beat(stack_words[idx], STS_OK, idx == 0));
                    end
                end
            end
            default: begin
                // Unused command codes leave the stack alone and answer nothing.
            end
        endcase
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            stack_count = 0;
        end else begin
            // Results are compared before this edge's command is predicted,
            // since a command cannot be answered on the edge that takes it.
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result beat data=%0d status=%0d last=%0d",
                                 $realtime, m_data.data, m_data.status, m_data.last);
                    end
                end else begin
                    want = beats_due.pop_front();
                    if (m_data.data !== want.data || m_data.status !== want.status ||
                        m_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: result mismatch: expected data=%0d status=%0d",
                                      " last=%0d, got data=%0d status=%0d last=%0d"},
                                     $realtime, want.data, want.status, want.last,
                                     m_data.data, m_data.status, m_data.last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_command(s_data);
            end
        end
        fail_count  <= mismatches;
        outstanding <= beats_due.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bounded stack with directed corner cases and then biased random
// command streams, stalls both channels at random and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import bsia_pkg::*;

    localparam int STACK_DEPTH = 8;
    localparam int RANDOM_BEATS = 80;
    // Codes outside the command set, which the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    int        fail_count;
    int        outstanding;
    int        ready_left = 0;

    always #6 aclk = ~aclk;

    bounded_stack_with_indexed_access #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    stack_checker #(
        .DEPTH(STACK_DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_ready && $urandom_range(0, 9) < 7) begin
            m_ready    <= 1'b0;
            ready_left <= idle_len();
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 24);
        end
    end

    // Offers one command beat after a random gap and holds it until taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic signed [WORD_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{command: cmd, value: val, position: pos};
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        int sent;
        int r;
        int push_weight;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stack corner cases.
        send_beat(CMD_DUMP, '0, '0);
        send_beat(CMD_POP, rand_word(), 4'd1);
        send_beat(CMD_PEEK, '0, 4'd0);
        send_beat(CMD_CHANGE, rand_word(), 4'd1);
        send_beat(CMD_UNUSED_LO, rand_word(), 4'd15);
        // Fill to capacity with the word extremes in the mix, then overflow.
        send_beat(CMD_PUSH, WORD_MAX, '0);
        send_beat(CMD_PUSH, WORD_MIN, '0);
        send_beat(CMD_PUSH, -1, '0);
        send_beat(CMD_PUSH, '0, '0);
        repeat (STACK_DEPTH - 4) send_beat(CMD_PUSH, rand_word(), '0);
        send_beat(CMD_PUSH, rand_word(), '0);
        send_beat(CMD_PEEK, '0, 4'd1);
        send_beat(CMD_PEEK, '0, 4'd8);
        send_beat(CMD_PEEK, '0, 4'd9);
        send_beat(CMD_CHANGE, 32'sh5A5A_A5A5, 4'd0);
        send_beat(CMD_CHANGE, 32'sh5A5A_A5A5, 4'd8);
        send_beat(CMD_CHANGE, WORD_MIN, 4'd1);
        send_beat(CMD_DUMP, '0, '0);
        send_beat(CMD_UNUSED_HI, WORD_MAX, 4'd7);
        send_beat(CMD_POP, '0, '0);
        send_beat(CMD_PEEK, '0, 4'd15);
        send_beat(CMD_DUMP, '0, '0);

        // Random part: alternate between filling and draining phases so the
        // stack keeps crossing both the full and the empty boundary.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            push_weight = ((sent / 20) % 2 == 0) ? 45 : 15;
            r = $urandom_range(0, 99);
            if (r < push_weight) cmd = CMD_PUSH;
            else if (r < 60) cmd = CMD_POP;
            else if (r < 75) cmd = CMD_PEEK;
            else if (r < 87) cmd = CMD_CHANGE;
            else if (r < 95) cmd = CMD_DUMP;
            else cmd = CMD_UNUSED_HI - CMD_W'($urandom_range(0, 2));
            r = $urandom_range(0, 99);
            if (r < 12) pos = 4'd0;
            else if (r < 85) pos = POS_W'($urandom_range(1, STACK_DEPTH));
            else pos = POS_W'($urandom_range(STACK_DEPTH + 1, 15));
            send_beat(cmd, rand_word(), pos);
            if (cmd <= CMD_DUMP) sent++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // Let any late or spurious beat show up before the verdict.
        repeat (3 * STACK_DEPTH) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_200_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bsia_pkg.sv
hdl/bsia_ram.sv
hdl/bounded_stack_with_indexed_access.sv
bench/stack_checker.sv
bench/tb_top.sv
